// File: design/cibw_pkg.sv
package cibw_pkg;

    localparam logic [1:0] ACT_COMP  = 2'd0;
    localparam logic [1:0] ACT_RAW   = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [7:0] MATCH_SIGNED   = 8'hFF;
    localparam logic [7:0] MATCH_UNSIGNED = 8'h00;
    localparam logic [7:0] NIB_MASK       = 8'hF0;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] value;
        logic [6:0]  width_bits;
        logic        is_signed;
        logic        left_aligned;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] valid_bits;
        logic       last;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_PUSH
    } t_ctrl_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic no_work;
        logic blocked;
        logic last_chunk;
    } t_dp_status;

endpackage

// File: design/cibw_ctrl.sv
module cibw_ctrl
    import cibw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_ctrl_cmd  o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.no_work ? ST_IDLE : ST_PUSH;
            end
            ST_PUSH: begin
                if (!i_status.blocked) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_chunk) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/cibw_dp.sv
module cibw_dp
    import cibw_pkg::*;
#(
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  t_in_beat   i_in_data,
    input  t_ctrl_cmd  i_cmd,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_beat  o_out_data
);

    // latched item
    logic [1:0]  r_act;
    logic [63:0] r_value;
    logic [6:0]  r_width;
    logic        r_sgn;
    logic        r_left;
    logic        r_byte_order;

    // per-item plan, set in the setup cycle
    logic [2:0] r_top;
    logic       r_found;
    logic       r_nibm;
    logic [7:0] r_head;
    logic [3:0] r_hlen;
    logic [3:0] r_nchunk;
    logic [3:0] r_out_total;
    logic [3:0] r_full;
    logic [2:0] r_rem;
    logic [3:0] r_idx;
    logic [3:0] r_emit_cnt;

    // bit packer
    logic [7:0] r_pend;
    logic [2:0] r_pend_cnt;

    logic      r_out_valid;
    t_out_beat r_out;

    // setup logic
    logic [7:0] p_match;
    logic [3:0] p_nb;
    logic [2:0] p_top;
    logic       p_found;
    logic [2:0] p_m;
    logic       p_nibm;
    logic [7:0] p_ones;
    logic [6:0] p_raw_n;
    logic [6:0] p_len;
    logic [3:0] p_nchunk;
    logic [3:0] p_hlen;
    logic [7:0] p_sum;

    always_comb begin
        p_match = r_sgn ? MATCH_SIGNED : MATCH_UNSIGNED;
        p_nb    = r_width[6:3];
        if (p_nb == 4'd0) begin
            p_nb = 4'd1;
        end
        if (p_nb > 4'(MAX_VALUE_BYTES)) begin
            p_nb = 4'(MAX_VALUE_BYTES);
        end
        p_top   = 3'd0;
        p_found = 1'b0;
        // highest upper byte below the count that differs from the match byte
        for (int k = 1; k < 8; k++) begin
            if ((4'(k) < p_nb) && (r_value[k*8 +: 8] != p_match)) begin
                p_top   = 3'(k);
                p_found = 1'b1;
            end
        end
        p_m    = p_found ? 3'(p_nb - 4'd1 - {1'b0, p_top}) : 3'(p_nb - 4'd1);
        p_nibm = (r_value[7:0] & NIB_MASK) == (p_match & NIB_MASK);
        p_ones = ~(8'hFF << p_m);
        p_hlen = {1'b0, p_m} + 4'd1;

        p_raw_n = (r_width > 7'd64) ? 7'd64 : r_width;

        p_len    = 7'd0;
        p_nchunk = 4'd0;
        case (r_act)
            ACT_COMP: begin
                if (p_found) begin
                    p_len    = 7'(p_hlen) + {({1'b0, p_top} + 4'd1), 3'b000};
                    p_nchunk = {1'b0, p_top} + 4'd2;
                end else begin
                    p_len    = 7'(p_hlen) + (p_nibm ? 7'd4 : 7'd8);
                    p_nchunk = 4'd2;
                end
            end
            ACT_RAW: begin
                p_len    = p_raw_n;
                p_nchunk = p_raw_n[6:3] + {3'b000, p_raw_n[2:0] != 3'd0};
            end
            ACT_FLUSH: begin
                p_nchunk = 4'd1;
            end
            default: begin
                p_nchunk = 4'd0;
            end
        endcase
        p_sum = {1'b0, p_len} + {5'd0, r_pend_cnt};
    end

    // chunk of this step, right aligned, unused upper bits zero
    logic [2:0] c_bi;
    logic [7:0] c_byte;
    logic [7:0] c_data;
    logic [3:0] c_len;
    logic [7:0] c_left;
    logic [15:0] c_comb;
    logic [3:0] c_cnt;
    logic       c_emit;
    logic       c_flush;

    always_comb begin
        c_bi    = 3'd0;
        c_data  = 8'd0;
        c_len   = 4'd8;
        c_flush = (r_act == ACT_FLUSH);
        case (r_act)
            ACT_COMP: begin
                if (r_idx == 4'd0) begin
                    c_data = r_head;
                    c_len  = r_hlen;
                end else if (r_found) begin
                    c_bi = r_byte_order ? 3'(r_top - 3'(r_idx - 4'd1)) : 3'(r_idx - 4'd1);
                end else if (r_nibm) begin
                    c_len = 4'd4;
                end
            end
            ACT_RAW: begin
                if (r_idx < r_full) begin
                    c_bi = r_idx[2:0];
                end else begin
                    c_bi  = r_full[2:0];
                    c_len = {1'b0, r_rem};
                end
            end
            default: begin
                c_len = 4'd8;
            end
        endcase
        c_byte = r_value[{c_bi, 3'b000} +: 8];
        if (r_act == ACT_RAW) begin
            if (c_len == 4'd8) begin
                c_data = c_byte;
            end else if (r_left) begin
                c_data = c_byte >> (4'd8 - c_len);
            end else begin
                c_data = c_byte & ~(8'hFF << c_len);
            end
        end else if (r_act == ACT_COMP && r_idx != 4'd0) begin
            c_data = (!r_found && r_nibm) ? (c_byte & ~NIB_MASK) : c_byte;
        end
        c_left = c_data << (4'd8 - c_len);
        c_comb = {r_pend, 8'h00} | ({c_left, 8'h00} >> r_pend_cnt);
        c_cnt  = {1'b0, r_pend_cnt} + c_len;
        c_emit = c_flush ? (r_pend_cnt != 3'd0) : c_cnt[3];
    end

    always_comb begin
        o_status.no_work    = (p_nchunk == 4'd0);
        o_status.blocked    = c_emit && r_out_valid && i_out_stall;
        o_status.last_chunk = (r_idx == r_nchunk - 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_in_data.action;
            r_value <= i_in_data.value;
            r_width <= i_in_data.width_bits;
            r_sgn   <= i_in_data.is_signed;
            r_left  <= i_in_data.left_aligned;
        end
        if (i_cmd.prep) begin
            r_top       <= p_top;
            r_found     <= p_found;
            r_nibm      <= p_nibm;
            r_head      <= {p_ones[6:0], p_found ? 1'b0 : p_nibm};
            r_hlen      <= p_hlen;
            r_nchunk    <= p_nchunk;
            r_out_total <= (r_act == ACT_FLUSH) ? {3'd0, r_pend_cnt != 3'd0} : p_sum[6:3];
            r_full      <= p_raw_n[6:3];
            r_rem       <= p_raw_n[2:0];
        end
        if (i_cmd.step && c_emit) begin
            r_out.byte_out   <= c_flush ? r_pend : c_comb[15:8];
            r_out.valid_bits <= c_flush ? {1'b0, r_pend_cnt} : 4'd8;
            r_out.last       <= c_flush || (r_emit_cnt == r_out_total - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= 1'b0;
            r_pend       <= 8'd0;
            r_pend_cnt   <= 3'd0;
            r_idx        <= 4'd0;
            r_emit_cnt   <= 4'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_byte_order <= i_cfg_wdata;
            end
            if (i_cmd.prep) begin
                r_idx      <= 4'd0;
                r_emit_cnt <= 4'd0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + 4'd1;
                if (c_flush) begin
                    r_pend     <= 8'd0;
                    r_pend_cnt <= 3'd0;
                end else if (c_emit) begin
                    r_pend     <= c_comb[7:0];
                    r_pend_cnt <= c_cnt[2:0];
                end else begin
                    r_pend     <= c_comb[15:8];
                    r_pend_cnt <= c_cnt[2:0];
                end
                if (c_emit) begin
                    r_emit_cnt <= r_emit_cnt + 4'd1;
                end
            end
            if (i_cmd.step && c_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a held beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && c_emit) |-> !(r_out_valid && i_out_stall))
        else $error("output beat overwritten while stalled");

    // never more bytes than planned for the item
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && c_emit && !c_flush) |-> (r_emit_cnt < r_out_total))
        else $error("more bytes than planned");

    // unused low bits of the pending byte stay clear
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> ((r_pend & (8'hFF >> r_pend_cnt)) == 8'd0))
        else $error("pending byte has stray bits");

    // partial bytes only close an item
    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.valid_bits != 4'd8) |-> r_out.last)
        else $error("partial byte not marked last");

endmodule

// File: design/compressed_int_bit_writer.sv
// MSB-first bit packer with compressed integer coding. Each accepted beat is
// a compressed integer write, a raw write of 1 to 64 bits, or a flush of the
// pending partial byte; completed bytes leave on the output channel, the
// final one of each input beat marked last. A beat is accepted in the idle
// state, planned in the setup state, then merged into the pending byte one
// chunk of up to eight bits at a time; no new beat is taken until its last
// chunk is merged. The chunk merge completes at most one byte per cycle and
// waits while a completed byte is held in the stalled output register.
// byte_order is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while no beat is in progress, as the block does not enforce this.
module compressed_int_bit_writer
    import cibw_pkg::*;
#(
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    cibw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    cibw_dp #(
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
